/* hdl/fire_cell_update_assert.svh */
// ----------------------------------------------------------------------------
// Fire cell update assertion macros
// Concurrent checks used by the cell update kernel; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIRE_CELL_UPDATE_ASSERT_SVH
`define FIRE_CELL_UPDATE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define FCU_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fire_cell_update: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define FCU_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fire_cell_update: next-cycle check failed");
`else
`define FCU_ASSERT_IMP(label, clk, rst, ante, cons)
`define FCU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/fcu_pkg.sv */
// ----------------------------------------------------------------------------
// Fire cell update package
// Codes, fixed-point constants, pipeline record type and the glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package fcu_pkg;

  // Opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_IGNITE = 2'd1;
  localparam logic [1:0] OP_INIT   = 2'd2;

  // Cell states
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_FUEL    = 2'd1;
  localparam logic [1:0] ST_BURNING = 2'd2;
  localparam logic [1:0] ST_BURNED  = 2'd3;

  // Fuel kinds
  localparam logic [2:0] KIND_GRASS = 3'd0;
  localparam logic [2:0] KIND_SHRUB = 3'd1;
  localparam logic [2:0] KIND_TREE  = 3'd2;
  localparam logic [2:0] KIND_WATER = 3'd3;
  localparam logic [2:0] KIND_ROCK  = 3'd4;

  localparam logic [8:0]  AMBIENT_TEMP  = 9'd20;
  localparam logic [8:0]  FIRE_TEMP     = 9'd300;
  localparam logic [8:0]  MIN_DENSITY   = 9'd26;
  localparam logic [11:0] TIME_STEP_RST = 12'd16;

  // Burn duration bases, in seconds.
  localparam logic [8:0] BASE_GRASS = 9'd30;
  localparam logic [8:0] BASE_SHRUB = 9'd120;
  localparam logic [8:0] BASE_TREE  = 9'd300;

  // Ignition factors, scaled by 5.
  localparam logic [2:0] KF_GRASS = 3'd6;
  localparam logic [2:0] KF_TREE  = 3'd4;
  localparam logic [2:0] KF_OTHER = 3'd5;

  localparam logic [8:0]  MOIST_LIMIT = 9'd320;
  localparam logic [10:0] MOIST_FULL  = 11'd1280;
  localparam logic [8:0]  TEMP_KNEE   = 9'd50;
  localparam logic [9:0]  TEMP_FLAT   = 10'd100;
  localparam logic [9:0]  TEMP_TOP    = 10'd320;
  localparam logic [8:0]  DROP_SPAN   = 9'd300;

  // Divide by 2500: drop two bits, then multiply by ceil(2^40 / 625).
  localparam int          RECIP_SH = 40;
  localparam logic [30:0] RECIP    = 31'd1759218605;

  // Divider geometry: quotient below 512, remainder up to 41 bits.
  localparam int QW = 9;
  localparam int DW = 31;
  localparam int RW = 41;

  // Display characters
  localparam logic [6:0] CH_WATER   = 7'h7E;
  localparam logic [6:0] CH_ROCK    = 7'h23;
  localparam logic [6:0] CH_BLANK   = 7'h20;
  localparam logic [6:0] CH_GRASS   = 7'h2E;
  localparam logic [6:0] CH_SHRUB   = 7'h6F;
  localparam logic [6:0] CH_TREE    = 7'h54;
  localparam logic [6:0] CH_BURNING = 7'h2A;
  localparam logic [6:0] CH_BURNED  = 7'h78;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  st;
    logic [8:0]  dens;
    logic [15:0] t;
    logic [8:0]  temp;
    logic [15:0] chance;
    logic        do_div;
  } rec_t;

  function automatic logic [6:0] glyph_of(input logic [1:0] st, input logic [2:0] kind);
    logic [6:0] g;
    g = CH_BURNED;
    case (st)
      ST_EMPTY: begin
        if (kind == KIND_WATER) g = CH_WATER;
        else if (kind == KIND_ROCK) g = CH_ROCK;
        else g = CH_BLANK;
      end
      ST_FUEL: begin
        if (kind == KIND_SHRUB) g = CH_SHRUB;
        else if (kind == KIND_TREE) g = CH_TREE;
        else g = CH_GRASS;
      end
      ST_BURNING: g = CH_BURNING;
      default: g = CH_BURNED;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/fire_cell_update.sv */
// ----------------------------------------------------------------------------
// Fire cell update kernel
// Stateless per-cell update of a grid fire model, pipelined one cell a cycle.
// ----------------------------------------------------------------------------
// Usage: raise start with a cell record and an opcode on the input ports; the
// record is taken at a rising edge where start is high and busy is low. Busy
// is only high while rst is asserted, so a cell can be offered every cycle.
// Each cell gives exactly one result: done is high for one cycle, once the
// cell has passed stages 1 to 3, the divider and the output register, with
// the updated record, the ignition chance and the display glyph on the result
// ports. Results leave in the order cells arrived. The receiver cannot hold
// results off, and nothing in the pipeline ever waits.
// Throughput is one cell per cycle. The pipeline depth is set by the burn-out
// temperature division, which retires one quotient bit per stage over nine
// stages, behind three stages of multiplication and compare.
// The time step is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; write it only with the pipeline empty.
// Reset clears every stage's valid bit, so cells in flight are dropped, and
// returns the time step to 16 (one second).
// ----------------------------------------------------------------------------
`default_nettype none
`include "fire_cell_update_assert.svh"

module fire_cell_update (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [1:0]  cell_state,
  input  wire logic [2:0]  fuel_kind,
  input  wire logic [8:0]  density,
  input  wire logic [8:0]  moisture,
  input  wire logic [15:0] elapsed_burn,
  input  wire logic [8:0]  cell_temp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [11:0] cfg_data,
  output logic             done,
  output logic [1:0]       new_state,
  output logic [8:0]       new_density,
  output logic [15:0]      new_elapsed_burn,
  output logic [8:0]       new_temp,
  output logic [15:0]      ignite_chance,
  output logic [6:0]       glyph
);
  import fcu_pkg::*;

  logic [11:0] time_step;
  logic        accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      time_step <= cfg_data;
    end
  end

  // ---------------- Stage 1: opcode decode and first products ----------------
  rec_t        rec_c;
  logic        can_burn_in;
  logic        can_burn_res;
  logic [16:0] t_sum;
  logic [8:0]  base;
  logic [2:0]  kf;
  logic [10:0] mf;
  logic [9:0]  tf;
  logic [8:0]  dens_ch;

  always_comb begin
    can_burn_in = (cell_state == ST_FUEL) && (fuel_kind != KIND_WATER) &&
                  (fuel_kind != KIND_ROCK) && (density >= MIN_DENSITY);
    t_sum = {1'b0, elapsed_burn} + {5'd0, time_step};

    rec_c.kind   = fuel_kind;
    rec_c.st     = cell_state;
    rec_c.dens   = density;
    rec_c.t      = elapsed_burn;
    rec_c.temp   = cell_temp;
    rec_c.chance = 16'd0;
    rec_c.do_div = 1'b0;
    case (opcode)
      OP_INIT: begin
        if ((fuel_kind == KIND_WATER) || (fuel_kind == KIND_ROCK)) begin
          rec_c.st   = ST_EMPTY;
          rec_c.dens = 9'd0;
        end else begin
          rec_c.st = ST_FUEL;
        end
        rec_c.temp = AMBIENT_TEMP;
        rec_c.t    = 16'd0;
      end
      OP_IGNITE: begin
        if (can_burn_in) begin
          rec_c.st   = ST_BURNING;
          rec_c.t    = 16'd0;
          rec_c.temp = FIRE_TEMP;
        end
      end
      OP_TICK: begin
        if (cell_state == ST_BURNING) begin
          rec_c.do_div = 1'b1;
          rec_c.t      = t_sum[16] ? 16'hFFFF : t_sum[15:0];
        end
      end
      default: begin
      end
    endcase

    case (fuel_kind)
      KIND_SHRUB: base = BASE_SHRUB;
      KIND_TREE:  base = BASE_TREE;
      default:    base = BASE_GRASS;
    endcase

    // A tick on a burning cell never leaves a fuel cell, so the chance only
    // ever needs the record as it stands after this stage.
    can_burn_res = (rec_c.st == ST_FUEL) && (fuel_kind != KIND_WATER) &&
                   (fuel_kind != KIND_ROCK) && (rec_c.dens >= MIN_DENSITY);
    case (fuel_kind)
      KIND_GRASS: kf = KF_GRASS;
      KIND_TREE:  kf = KF_TREE;
      default:    kf = KF_OTHER;
    endcase
    mf      = MOIST_FULL - {moisture, 2'b00};
    tf      = (rec_c.temp > TEMP_KNEE) ? ({1'b0, rec_c.temp} + {1'b0, TEMP_KNEE}) : TEMP_FLAT;
    dens_ch = (can_burn_res && (moisture < MOIST_LIMIT)) ? rec_c.dens : 9'd0;
  end

  logic        s1_v;
  rec_t        s1_rec;
  logic [17:0] s1_bd;
  logic [9:0]  s1_m1;
  logic [11:0] s1_a;
  logic [20:0] s1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_rec <= rec_c;
    s1_bd  <= 18'(base) * 18'(density);
    s1_m1  <= 10'd256 + {1'b0, moisture};
    s1_a   <= 12'(dens_ch) * 12'(kf);
    s1_b   <= 21'(mf) * 21'(tf);
  end

  // ---------------- Stage 2: duration and numerators ----------------
  logic [27:0] bdm;
  logic        s2_v;
  rec_t        s2_rec;
  logic [DW-1:0] s2_dur;
  logic [24:0] s2_t300;
  logic [31:0] s2_num;

  assign bdm = 28'(s1_bd) * 28'(s1_m1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_rec  <= s1_rec;
    s2_dur  <= {bdm[26:0], 4'b0000};
    s2_t300 <= 25'(s1_rec.t) * 25'(DROP_SPAN);
    s2_num  <= 32'(s1_a) * 32'(s1_b);
  end

  // ---------------- Stage 3: burn-out compare, divider load ----------------
  logic          div_v   [QW+1];
  rec_t          div_rec [QW+1];
  logic [RW-1:0] div_rem [QW+1];
  logic [DW-1:0] div_d   [QW+1];
  logic [QW-1:0] div_q   [QW+1];
  logic [60:0]   s3_cp;
  logic          burned;
  rec_t          rec3;

  always_comb begin
    // A zero duration also lands here, so no quotient from a zero divisor is ever used.
    burned = {s2_rec.t, 16'd0} >= {1'b0, s2_dur};
    rec3   = s2_rec;
    if (s2_rec.do_div && burned) begin
      rec3.st     = ST_BURNED;
      rec3.dens   = 9'd0;
      rec3.temp   = AMBIENT_TEMP;
      rec3.do_div = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_v[0] <= 1'b0;
    end else begin
      div_v[0] <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    div_rec[0] <= rec3;
    div_rem[0] <= {s2_t300, 16'd0};
    div_d[0]   <= s2_dur;
    div_q[0]   <= '0;
    s3_cp      <= 61'(s2_num[31:2]) * 61'(RECIP);
  end

  // ---------------- Divider: one quotient bit per stage ----------------
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [RW-1:0] dsh;
    logic          fits;

    assign dsh  = RW'(div_d[j]) << SH;
    assign fits = div_rem[j] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        div_v[j+1] <= 1'b0;
      end else begin
        div_v[j+1] <= div_v[j];
      end
    end

    always_ff @(posedge clk) begin
      div_rem[j+1] <= fits ? (div_rem[j] - dsh) : div_rem[j];
      div_d[j+1]   <= div_d[j];
      div_q[j+1]   <= div_q[j] | (QW'(fits) << SH);
    end

    if (j == 0) begin : g_chance
      logic [20:0] cq;
      rec_t        rec_ch;

      // The chance quotient is clamped to the Q0.16 ceiling.
      always_comb begin
        cq            = s3_cp[60:RECIP_SH];
        rec_ch        = div_rec[0];
        rec_ch.chance = (|cq[20:16]) ? 16'hFFFF : cq[15:0];
      end

      always_ff @(posedge clk) begin
        div_rec[j+1] <= rec_ch;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        div_rec[j+1] <= div_rec[j];
      end
    end
  end

  // ---------------- Output stage ----------------
  rec_t       rec_o;
  logic [9:0] drop;
  logic [9:0] temp_calc;

  always_comb begin
    rec_o     = div_rec[QW];
    // Temperature drop is rounded up, hence the remainder term.
    drop      = 10'(div_q[QW]) + 10'(div_rem[QW] != '0);
    temp_calc = TEMP_TOP - drop;
    if (rec_o.do_div) begin
      rec_o.temp = temp_calc[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    new_state        <= rec_o.st;
    new_density      <= rec_o.dens;
    new_elapsed_burn <= rec_o.t;
    new_temp         <= rec_o.temp;
    ignite_chance    <= rec_o.chance;
    glyph            <= glyph_of(rec_o.st, rec_o.kind);
  end

  // ---------------- Checks ----------------
  `FCU_ASSERT_IMP(a_done_has_cell, clk, rst, done, $past(accept, 13))
  `FCU_ASSERT_IMP(a_chance_only_fuel, clk, rst, done && (new_state != ST_FUEL), ignite_chance == 16'd0)
  `FCU_ASSERT_IMP(a_drop_in_range, clk, rst, div_v[QW] && div_rec[QW].do_div, div_q[QW] < DROP_SPAN)
  `FCU_ASSERT_NXT(a_cell_reaches_div, clk, rst, s2_v, div_v[0])

endmodule

`default_nettype wire

/* tb/fire_cell_update_tb.sv */
// ----------------------------------------------------------------------------
// Fire cell update testbench
// Streams cell records through the kernel under several time steps and idle
// patterns, predicts each updated record in a scoreboard and checks every
// result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_cell_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcu_pkg::*;

  localparam logic [1:0] OP_SPARE  = 2'd3;
  localparam int         CFG_STEP  = 0;
  localparam int         LATENCY   = 12;
  localparam int         STALL_MAX = 500;
  localparam int         PER_PHASE = 215;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  state;
    logic [2:0]  kind;
    logic [8:0]  dens;
    logic [8:0]  moist;
    logic [15:0] burn;
    logic [8:0]  temp;
  } cell_in_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [8:0]  dens;
    logic [15:0] burn;
    logic [8:0]  temp;
    logic [15:0] chance;
    logic [6:0]  glyph;
  } cell_out_t;

  class cell_ledger;
    cell_out_t   awaited[$];
    logic [11:0] step = 12'd16;
    int          fails = 0;
    int          cells = 0;
    int          burnouts = 0;
    int          saturated = 0;

    function bit burnable(logic [1:0] st, logic [2:0] kind, logic [8:0] dens);
      return st == ST_FUEL && kind != KIND_WATER && kind != KIND_ROCK && dens >= 9'd26;
    endfunction

    function logic [15:0] ignition(logic [1:0] st, logic [2:0] kind, logic [8:0] dens,
                                   logic [8:0] moist, logic [8:0] temp);
      longint unsigned kf, mf, tf, q;
      if (!burnable(st, kind, dens)) return 16'd0;
      kf = (kind == KIND_GRASS) ? 6 : (kind == KIND_TREE) ? 4 : 5;
      if (4 * longint'(moist) >= 1280) return 16'd0;
      mf = 1280 - 4 * longint'(moist);
      tf = (temp > 9'd50) ? 50 + longint'(temp) : 100;
      q = longint'(dens) * kf * mf * tf / 2500;
      return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    function logic [6:0] symbol(logic [1:0] st, logic [2:0] kind);
      case (st)
        ST_EMPTY: begin
          if (kind == KIND_WATER) return 7'("~");
          if (kind == KIND_ROCK) return 7'("#");
          return 7'(" ");
        end
        ST_FUEL: begin
          if (kind == KIND_SHRUB) return 7'("o");
          if (kind == KIND_TREE) return 7'("T");
          return 7'(".");
        end
        ST_BURNING: return 7'("*");
        default: return 7'("x");
      endcase
    endfunction

    function cell_out_t update_cell(cell_in_t c);
      cell_out_t       r;
      longint unsigned tw, base, dur, drop;
      r.state = c.state;
      r.dens  = c.dens;
      r.burn  = c.burn;
      r.temp  = c.temp;
      case (c.op)
        OP_INIT: begin
          if (c.kind == KIND_WATER || c.kind == KIND_ROCK) begin
            r.state = ST_EMPTY;
            r.dens  = 9'd0;
          end else begin
            r.state = ST_FUEL;
          end
          r.temp = 9'd20;
          r.burn = 16'd0;
        end
        OP_IGNITE: begin
          if (burnable(c.state, c.kind, c.dens)) begin
            r.state = ST_BURNING;
            r.burn  = 16'd0;
            r.temp  = 9'd300;
          end
        end
        OP_TICK: begin
          if (c.state == ST_BURNING) begin
            tw = longint'(c.burn) + longint'(step);
            if (tw > 65535) begin
              tw = 65535;
              saturated++;
            end
            base = (c.kind == KIND_SHRUB) ? 120 : (c.kind == KIND_TREE) ? 300 : 30;
            // Duration is kept scaled by 65536 so that the compare is exact.
            dur = base * 16 * longint'(c.dens) * (256 + longint'(c.moist));
            r.burn = tw[15:0];
            if (tw * 65536 >= dur) begin
              r.state = ST_BURNED;
              r.temp  = 9'd20;
              r.dens  = 9'd0;
              burnouts++;
            end else begin
              drop   = (300 * tw * 65536 + dur - 1) / dur;
              r.temp = 9'(320 - drop);
            end
          end
        end
        default: ;
      endcase
      r.chance = ignition(r.state, c.kind, r.dens, c.moist, r.temp);
      r.glyph  = symbol(r.state, c.kind);
      return r;
    endfunction

    function void note_cell(cell_in_t c);
      awaited.push_back(update_cell(c));
      cells++;
    endfunction

    function void check_cell(cell_out_t got);
      cell_out_t want;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("result strobe with no cell outstanding: %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected st=%0d dens=%0d burn=%0d temp=%0d chance=%0d glyph=%h,",
                   want.state, want.dens, want.burn, want.temp, want.chance, want.glyph,
                   " got st=%0d dens=%0d burn=%0d temp=%0d chance=%0d glyph=%h",
                   got.state, got.dens, got.burn, got.temp, got.chance, got.glyph);
      end
    endfunction

    function void close_out();
      if (awaited.size() != 0) begin
        fails += awaited.size();
        $display("%0d results never arrived", awaited.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  cell_in_t    offer = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [11:0] cfg_data = '0;
  logic        done;
  cell_out_t   got;

  cell_ledger  ledger = new();
  int          idle_pct = 0;
  int          stalled = 0;
  int          settings = 1;

  always #4 clk = ~clk;

  fire_cell_update dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (offer.op),
    .cell_state      (offer.state),
    .fuel_kind       (offer.kind),
    .density         (offer.dens),
    .moisture        (offer.moist),
    .elapsed_burn    (offer.burn),
    .cell_temp       (offer.temp),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .done            (done),
    .new_state       (got.state),
    .new_density     (got.dens),
    .new_elapsed_burn(got.burn),
    .new_temp        (got.temp),
    .ignite_chance   (got.chance),
    .glyph           (got.glyph)
  );

  // Transfers are observed here, on the values held through the cycle that ends.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.step = cfg_data;
      if (start && !busy) ledger.note_cell(offer);
      if (done) ledger.check_cell(got);
      if ((cfg_valid && cfg_ready) || (start && !busy) || done) begin
        stalled = 0;
      end else begin
        stalled++;
        if (stalled >= STALL_MAX) begin
          $display("watchdog: no transfer for %0d cycles", STALL_MAX);
          $display("fire_cell_update verification failed");
          $finish;
        end
      end
    end
  end

  task automatic send_cell(cell_in_t c);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    offer <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_step(logic [11:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic cell_in_t mk(logic [1:0] op, logic [1:0] st, logic [2:0] kind,
                                  int dens, int moist, int burn, int temp);
    cell_in_t c;
    c.op    = op;
    c.state = st;
    c.kind  = kind;
    c.dens  = 9'(dens);
    c.moist = 9'(moist);
    c.burn  = 16'(burn);
    c.temp  = 9'(temp);
    return c;
  endfunction

  function automatic cell_in_t random_cell();
    cell_in_t c;
    int       pick, base, dur_t, target;
    c = '{op: 2'($urandom_range(3)), state: 2'($urandom_range(3)),
          kind: 3'($urandom_range(7)), dens: 9'($urandom), moist: 9'($urandom),
          burn: 16'($urandom), temp: 9'($urandom)};
    if ($urandom_range(2) != 0) c.moist = 9'($urandom_range(256));
    pick = $urandom_range(99);
    if (pick < 55) begin
      // Burning cell on a tick, with the burn time often close to burn-out or to saturation.
      c.op    = OP_TICK;
      c.state = ST_BURNING;
      if ($urandom_range(9) == 0) c.dens = 9'($urandom_range(3));
      base  = (c.kind == KIND_SHRUB) ? 120 : (c.kind == KIND_TREE) ? 300 : 30;
      dur_t = (base * 16 * int'(c.dens) * (256 + int'(c.moist))) >>> 16;
      case ($urandom_range(9))
        0, 1, 2, 3: target = dur_t - int'(ledger.step) + $urandom_range(4) - 2;
        4:          target = 65535 - $urandom_range(int'(ledger.step) + 2);
        default:    target = $urandom_range(dur_t);
      endcase
      if (target < 0) target = 0;
      if (target > 65535) target = 65535;
      c.burn = 16'(target);
    end else if (pick < 72) begin
      c.op = OP_IGNITE;
      if ($urandom_range(3) != 0) c.state = ST_FUEL;
      if ($urandom_range(3) == 0) c.dens = 9'(24 + $urandom_range(4));
    end else if (pick < 82) begin
      c.op = OP_INIT;
    end else if (pick < 90) begin
      c.op = OP_TICK;
    end
    return c;
  endfunction

  task automatic directed_cells();
    cell_in_t list[$];
    list.push_back(mk(OP_INIT,   ST_EMPTY,   KIND_GRASS, 300, 100, 1234, 400));
    list.push_back(mk(OP_INIT,   ST_BURNING, KIND_WATER, 200, 0,   50,   300));
    list.push_back(mk(OP_INIT,   ST_BURNED,  KIND_ROCK,  511, 256, 9,    100));
    list.push_back(mk(OP_INIT,   ST_FUEL,    3'd7,       511, 511, 65535, 511));
    list.push_back(mk(OP_INIT,   ST_FUEL,    KIND_SHRUB, 0,   0,   0,    0));
    // Ignite right at the minimum fuel density and one below it.
    list.push_back(mk(OP_IGNITE, ST_FUEL,    KIND_SHRUB, 26,  10,  77,   20));
    list.push_back(mk(OP_IGNITE, ST_FUEL,    KIND_TREE,  25,  10,  77,   20));
    list.push_back(mk(OP_IGNITE, ST_FUEL,    KIND_WATER, 300, 0,   0,    20));
    list.push_back(mk(OP_IGNITE, ST_BURNED,  KIND_GRASS, 300, 0,   0,    20));
    list.push_back(mk(OP_IGNITE, ST_FUEL,    KIND_GRASS, 511, 0,   0,    20));
    list.push_back(mk(OP_IGNITE, ST_FUEL,    3'd5,       100, 511, 0,    20));
    // Grass at density 1.0 and no moisture lasts exactly 480 sixteenths.
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_GRASS, 256, 0,   464,  300));
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_GRASS, 256, 0,   463,  300));
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_SHRUB, 0,   0,   0,    300));
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_TREE,  511, 256, 65535, 300));
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_TREE,  511, 256, 0,    300));
    list.push_back(mk(OP_TICK,   ST_BURNING, KIND_SHRUB, 200, 511, 1000, 250));
    list.push_back(mk(OP_TICK,   ST_FUEL,    KIND_GRASS, 300, 319, 5,    51));
    list.push_back(mk(OP_TICK,   ST_FUEL,    KIND_GRASS, 300, 320, 5,    50));
    list.push_back(mk(OP_TICK,   ST_EMPTY,   KIND_WATER, 0,   0,   0,    20));
    list.push_back(mk(OP_TICK,   ST_BURNED,  KIND_TREE,  0,   0,   400,  20));
    list.push_back(mk(OP_SPARE,  ST_FUEL,    KIND_GRASS, 300, 0,   0,    20));
    list.push_back(mk(OP_SPARE,  ST_BURNING, KIND_TREE,  300, 0,   10,   300));
    foreach (list[i]) send_cell(list[i]);
  endtask

  initial begin
    logic [11:0] steps[8];
    int          modes[3];
    steps = '{12'd16, 12'd1, 12'd4095, 12'd16, 12'd0, 12'd0, 12'd2048, 12'd0};
    modes = '{0, 62, 34};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_cells();
    for (int ph = 0; ph < 8; ph++) begin
      // The first phase runs on the reset value of the time step.
      if (ph > 0) begin
        drain();
        if (steps[ph] == 12'd0) steps[ph] = 12'($urandom_range(4095, 1));
        write_step(steps[ph]);
        settings++;
      end
      for (int n = 0; n < PER_PHASE; n++) begin
        if (n % 32 == 0)
          idle_pct = ($urandom_range(3) == 0) ? 0 : modes[ph % 3];
        send_cell(random_cell());
      end
    end
    drain();

    ledger.close_out();
    $display("%0d cells checked over %0d time-step settings (1 to 4095) with varied idling;",
             ledger.cells, settings);
    $display("%0d burn-outs and %0d saturated burn times predicted, %0d failures",
             ledger.burnouts, ledger.saturated, ledger.fails);
    if (ledger.fails == 0) begin
      $display("fire_cell_update verification clean");
    end else begin
      $display("fire_cell_update verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
